/* sv/persistent_range_sum_tree_macros.svh */
// Assertion helpers used by the engine RTL; clk and rst are taken from the enclosing module.
`ifndef PERSISTENT_RANGE_SUM_TREE_MACROS_SVH
`define PERSISTENT_RANGE_SUM_TREE_MACROS_SVH

`define PRST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PRST_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* sv/prst_pkg.sv */
package prst_pkg;

  localparam int TOTAL_W = 44;
  localparam logic [12:0] LENGTH_RESET = 13'd4096;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_SUM  = 2'd1,
    OP_COPY = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_VER   = 3'd1,
    ST_BAD_IDX   = 3'd2,
    ST_POOL_FULL = 3'd3,
    ST_VER_FULL  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_DOWN_RD,
    S_DOWN_WAIT,
    S_UP_LEAF,
    S_UP_RD,
    S_UP_WAIT,
    S_SUM_POP,
    S_SUM_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    opcode_e      op;
    logic [9:0]   ver;
    logic [11:0]  pos;
    logic [31:0]  val;
    logic [11:0]  lo;
    logic [11:0]  hi;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [9:0]         new_version;
    status_e            status;
  } result_t;

endpackage

/* sv/prst_pool.sv */
// Node pool: one read and one write port, registered read. Node 0 always reads as
// the empty subtree, so the pool needs no clearing.
module prst_pool import prst_pkg::*; #(
  parameter int POOL_NODES = 65536
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(POOL_NODES)-1:0]  rd_addr,
  output logic [TOTAL_W-1:0]             rd_total,
  output logic [$clog2(POOL_NODES)-1:0]  rd_left,
  output logic [$clog2(POOL_NODES)-1:0]  rd_right,
  input  logic                           we,
  input  logic [$clog2(POOL_NODES)-1:0]  waddr,
  input  logic [TOTAL_W-1:0]             wtotal,
  input  logic [$clog2(POOL_NODES)-1:0]  wleft,
  input  logic [$clog2(POOL_NODES)-1:0]  wright
);

  localparam int NW = $clog2(POOL_NODES);
  localparam int RW = TOTAL_W + 2 * NW;

  logic [RW-1:0] mem [POOL_NODES];
  logic [RW-1:0] rd_q;
  logic          rd_zero;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wtotal, wleft, wright};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_zero <= (rd_addr == '0);
    end
  end

  assign rd_total = rd_zero ? '0 : rd_q[RW-1 -: TOTAL_W];
  assign rd_left  = rd_zero ? '0 : rd_q[2*NW-1 -: NW];
  assign rd_right = rd_zero ? '0 : rd_q[NW-1:0];

endmodule

/* sv/prst_roots.sv */
// Root table, one entry per version. Version 0 reads as node 0 until first written;
// other versions are always written by a copy before they can be read.
module prst_roots #(
  parameter int MAX_VERSIONS = 1024,
  parameter int POOL_NODES   = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [$clog2(MAX_VERSIONS)-1:0] rd_addr,
  output logic [$clog2(POOL_NODES)-1:0]   rd_data,
  input  logic                            we,
  input  logic [$clog2(MAX_VERSIONS)-1:0] waddr,
  input  logic [$clog2(POOL_NODES)-1:0]   wdata
);

  localparam int NW = $clog2(POOL_NODES);

  logic [NW-1:0] mem [MAX_VERSIONS];
  logic [NW-1:0] rd_q;
  logic          rd_zero;
  logic          v0_written;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0_written <= 1'b0;
    end else if (we && waddr == '0) begin
      v0_written <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_zero <= (rd_addr == '0) && !v0_written;
    end
  end

  assign rd_data = rd_zero ? '0 : rd_q;

endmodule

/* sv/prst_engine.sv */
// Operation sequencer: path copy for set, stack walk for range sum, root copy.
module prst_engine import prst_pkg::*; #(
  parameter int MAX_LEAVES   = 4096,
  parameter int POOL_NODES   = 65536,
  parameter int MAX_VERSIONS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [12:0] span_cfg,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

`include "persistent_range_sum_tree_macros.svh"

  localparam int PW   = $clog2(MAX_LEAVES);
  localparam int LVLS = PW + 1;
  localparam int LVW  = $clog2(LVLS);
  localparam int SD   = 2 * LVLS;
  localparam int SIW  = $clog2(SD);
  localparam int SPW  = $clog2(SD + 1);
  localparam int NW   = $clog2(POOL_NODES);
  localparam int FW   = NW + 1;
  localparam int VW   = $clog2(MAX_VERSIONS);
  localparam int VCW  = $clog2(MAX_VERSIONS + 1);

  state_e state, state_next;

  opcode_e         op;
  logic [9:0]      ver_q;
  logic [PW-1:0]   pos_q, ra, rb, last, lo, hi, mid;
  logic [31:0]     val_q;
  logic [NW-1:0]   cur;
  logic [LVW-1:0]  lvl, dep;
  logic [TOTAL_W-1:0] ctot, acc;
  logic            cov;
  logic [NW-1:0]   sib [LVLS];
  logic            dir [LVLS];
  logic [NW-1:0]   stk_node [SD];
  logic [PW-1:0]   stk_lo [SD];
  logic [PW-1:0]   stk_hi [SD];
  logic [SPW-1:0]  sp, sp_m1, sp_p1;
  logic [SIW-1:0]  top;
  logic [FW-1:0]   nf;
  logic [VCW-1:0]  vc;

  logic [31:0]     span_len;
  logic            early_done;
  status_e         early_status;
  logic            covers, push_l, push_r;
  logic [NW-1:0]   fresh, child;

  logic               node_rd_en, node_we;
  logic [NW-1:0]      node_rd_addr, node_waddr, node_wleft, node_wright;
  logic [NW-1:0]      node_rd_left, node_rd_right;
  logic [TOTAL_W-1:0] node_rd_total, node_wtotal;
  logic               root_rd_en, root_we;
  logic [VW-1:0]      root_rd_addr, root_waddr;
  logic [NW-1:0]      root_rd_data, root_wdata;

  prst_pool #(.POOL_NODES(POOL_NODES)) u_pool (
    .clk      (clk),
    .rd_en    (node_rd_en),
    .rd_addr  (node_rd_addr),
    .rd_total (node_rd_total),
    .rd_left  (node_rd_left),
    .rd_right (node_rd_right),
    .we       (node_we),
    .waddr    (node_waddr),
    .wtotal   (node_wtotal),
    .wleft    (node_wleft),
    .wright   (node_wright)
  );

  prst_roots #(.MAX_VERSIONS(MAX_VERSIONS), .POOL_NODES(POOL_NODES)) u_roots (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (root_rd_en),
    .rd_addr (root_rd_addr),
    .rd_data (root_rd_data),
    .we      (root_we),
    .waddr   (root_waddr),
    .wdata   (root_wdata)
  );

  always_comb begin
    if (span_cfg == '0) begin
      span_len = 32'd1;
    end else if (32'(span_cfg) > 32'(MAX_LEAVES)) begin
      span_len = 32'(MAX_LEAVES);
    end else begin
      span_len = 32'(span_cfg);
    end
  end

  // checks that finish an item without touching the trees
  always_comb begin
    early_done   = 1'b1;
    early_status = ST_OK;
    if (item.op == OP_NONE) begin
      early_status = ST_OK;
    end else if (32'(item.ver) >= 32'(vc)) begin
      early_status = ST_BAD_VER;
    end else if (item.op == OP_SET && 32'(item.pos) >= span_len) begin
      early_status = ST_BAD_IDX;
    end else if (item.op == OP_SUM &&
                 (32'(item.lo) >= span_len || 32'(item.hi) >= span_len)) begin
      early_status = ST_BAD_IDX;
    end else if (item.op == OP_SUM && item.lo > item.hi) begin
      early_status = ST_OK;
    end else if (item.op == OP_COPY && 32'(vc) >= 32'(MAX_VERSIONS)) begin
      early_status = ST_VER_FULL;
    end else begin
      early_done = 1'b0;
    end
  end

  assign mid    = lo + ((hi - lo) >> 1);
  assign sp_m1  = sp - SPW'(1);
  assign sp_p1  = sp + SPW'(1);
  assign top    = sp_m1[SIW-1:0];
  assign covers = (ra <= stk_lo[top]) && (stk_hi[top] <= rb);
  assign push_l = (ra <= mid);
  assign push_r = (rb > mid);
  // fresh nodes are allocated root first, one per level
  assign fresh  = NW'(nf + FW'(lvl));
  assign child  = NW'(nf + FW'(lvl) + FW'(1));

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    node_rd_en   = 1'b0;
    node_rd_addr = cur;
    node_we      = 1'b0;
    node_waddr   = fresh;
    node_wtotal  = ctot;
    node_wleft   = '0;
    node_wright  = '0;
    root_rd_en   = 1'b0;
    root_rd_addr = VW'(item.ver);
    root_we      = 1'b0;
    root_waddr   = VW'(ver_q);
    root_wdata   = NW'(nf);
    case (state)
      S_IDLE: begin
        root_rd_en = item_valid;
        if (item_valid) begin
          state_next = early_done ? S_DONE : S_ROOT;
        end
      end
      S_ROOT: begin
        case (op)
          OP_COPY: begin
            root_we    = 1'b1;
            root_waddr = VW'(vc);
            root_wdata = root_rd_data;
            state_next = S_DONE;
          end
          OP_SET:  state_next = S_DOWN_RD;
          default: state_next = S_SUM_POP;
        endcase
      end
      S_DOWN_RD: begin
        if (lo == hi) begin
          if (32'(nf) + 32'(lvl) + 32'd1 > 32'(POOL_NODES)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_UP_LEAF;
          end
        end else begin
          node_rd_en = 1'b1;
          state_next = S_DOWN_WAIT;
        end
      end
      S_DOWN_WAIT: state_next = S_DOWN_RD;
      S_UP_LEAF: begin
        node_we     = 1'b1;
        node_wtotal = TOTAL_W'(val_q);
        if (lvl == '0) begin
          root_we    = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_UP_RD: begin
        node_rd_en   = 1'b1;
        node_rd_addr = sib[lvl];
        state_next   = S_UP_WAIT;
      end
      S_UP_WAIT: begin
        node_we     = 1'b1;
        node_wtotal = ctot + node_rd_total;
        node_wleft  = dir[lvl] ? sib[lvl] : child;
        node_wright = dir[lvl] ? child : sib[lvl];
        if (lvl == '0) begin
          root_we    = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_SUM_POP: begin
        node_rd_addr = stk_node[top];
        if (sp == '0) begin
          state_next = S_DONE;
        end else if (stk_node[top] != '0) begin
          node_rd_en = 1'b1;
          state_next = S_SUM_WAIT;
        end
      end
      S_SUM_WAIT: state_next = S_SUM_POP;
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nf <= FW'(1);
      vc <= VCW'(1);
      sp <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            op    <= item.op;
            ver_q <= item.ver;
            pos_q <= PW'(item.pos);
            val_q <= item.val;
            ra    <= PW'(item.lo);
            rb    <= PW'(item.hi);
            last  <= PW'(span_len - 32'd1);
            res   <= '{total: '0, new_version: '0, status: early_status};
          end
        end
        S_ROOT: begin
          case (op)
            OP_COPY: begin
              res.new_version <= 10'(vc);
              vc <= vc + VCW'(1);
            end
            OP_SET: begin
              cur <= root_rd_data;
              lo  <= '0;
              hi  <= last;
              lvl <= '0;
            end
            default: begin
              stk_node[0] <= root_rd_data;
              stk_lo[0]   <= '0;
              stk_hi[0]   <= last;
              sp          <= SPW'(1);
              acc         <= '0;
            end
          endcase
        end
        S_DOWN_RD: begin
          dep <= lvl;
          if (lo == hi && 32'(nf) + 32'(lvl) + 32'd1 > 32'(POOL_NODES)) begin
            res.status <= ST_POOL_FULL;
          end
        end
        S_DOWN_WAIT: begin
          if (pos_q <= mid) begin
            dir[lvl] <= 1'b0;
            sib[lvl] <= node_rd_right;
            cur      <= node_rd_left;
            hi       <= mid;
          end else begin
            dir[lvl] <= 1'b1;
            sib[lvl] <= node_rd_left;
            cur      <= node_rd_right;
            lo       <= mid + PW'(1);
          end
          lvl <= lvl + LVW'(1);
        end
        S_UP_LEAF: begin
          ctot <= TOTAL_W'(val_q);
          if (lvl == '0) begin
            nf <= nf + FW'(1);
          end else begin
            lvl <= lvl - LVW'(1);
          end
        end
        S_UP_WAIT: begin
          ctot <= ctot + node_rd_total;
          if (lvl == '0) begin
            nf <= nf + FW'(dep) + FW'(1);
          end else begin
            lvl <= lvl - LVW'(1);
          end
        end
        S_SUM_POP: begin
          if (sp == '0) begin
            res.total <= acc;
          end else begin
            sp  <= sp_m1;
            cur <= stk_node[top];
            lo  <= stk_lo[top];
            hi  <= stk_hi[top];
            cov <= covers;
          end
        end
        S_SUM_WAIT: begin
          if (cov) begin
            acc <= acc + node_rd_total;
          end else begin
            // only children that meet the range go on the stack
            if (push_l) begin
              stk_node[sp[SIW-1:0]] <= node_rd_left;
              stk_lo[sp[SIW-1:0]]   <= lo;
              stk_hi[sp[SIW-1:0]]   <= mid;
            end
            if (push_r) begin
              stk_node[push_l ? sp_p1[SIW-1:0] : sp[SIW-1:0]] <= node_rd_right;
              stk_lo[push_l ? sp_p1[SIW-1:0] : sp[SIW-1:0]]   <= mid + PW'(1);
              stk_hi[push_l ? sp_p1[SIW-1:0] : sp[SIW-1:0]]   <= hi;
            end
            sp <= sp + SPW'(push_l) + SPW'(push_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  `PRST_NEVER(a_pool_bound, 32'(nf) > 32'(POOL_NODES), "free node pointer past pool end")
  `PRST_NEVER(a_ver_bound, vc == '0 || 32'(vc) > 32'(MAX_VERSIONS), "version count out of range")
  `PRST_NEVER(a_no_node0_write, node_we && node_waddr == '0, "write to shared zero node")
  `PRST_ASSERT(a_accept_leaves_idle, (item_valid && item_ready) |=> state != S_IDLE,
               "accepted transaction not started")

endmodule

/* sv/persistent_range_sum_tree.sv */
// Persistent range-sum tree.
// Input channel (in_valid/in_ready): one transaction per operation: set, range
// sum or copy version. Output channel (out_valid/out_ready): exactly one result
// per input, in order. The config channel (cfg_valid/cfg_ready) writes
// active_length and is always ready; write it only while the block is idle.
// Items are handled one at a time; in_ready is high when the sequencer is idle.
// Timing is set by the single read port of the node pool: an item stopped by a
// check or a copy reads no nodes, a set reads one node per level on the way down
// and one sibling per level on the way up, and a sum reads each visited node (up
// to about four nodes per level); the tree has 13 levels for 4096 elements.
// in_ready returns in the cycle after a result enters the output register.
// A finished result sits in the output register; the next item is accepted
// while it waits, and that item completes once the register is free, so a
// stalled receiver holds back at most one further item.
// Reset: version 0 is all zeros, one version, empty pool; active_length = 4096.
// No clearing pass is needed after reset.
module persistent_range_sum_tree import prst_pkg::*; #(
  parameter int MAX_LEAVES   = 4096,
  parameter int POOL_NODES   = 65536,
  parameter int MAX_VERSIONS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [12:0]  active_length,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   opcode,
  input  logic [9:0]   version_sel,
  input  logic [11:0]  position,
  input  logic [31:0]  value,
  input  logic [11:0]  range_low,
  input  logic [11:0]  range_high,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [43:0]  range_total,
  output logic [9:0]   new_version,
  output logic [2:0]   status
);

  logic [12:0] span_cfg;
  item_t       item;
  result_t     res;
  logic        res_valid, res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_cfg <= LENGTH_RESET;
    end else if (cfg_valid) begin
      span_cfg <= active_length;
    end
  end

  assign item = '{op: opcode_e'(opcode), ver: version_sel, pos: position, val: value,
                  lo: range_low, hi: range_high};

  prst_engine #(
    .MAX_LEAVES   (MAX_LEAVES),
    .POOL_NODES   (POOL_NODES),
    .MAX_VERSIONS (MAX_VERSIONS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .span_cfg   (span_cfg),
    .item_valid (in_valid),
    .item_ready (in_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      range_total <= res.total;
      new_version <= res.new_version;
      status      <= res.status;
    end
  end

endmodule

/* verif/persistent_range_sum_tree_chk.sv */
module persistent_range_sum_tree_chk import prst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [12:0] active_length,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [9:0]  version_sel,
  input  logic [11:0] position,
  input  logic [31:0] value,
  input  logic [11:0] range_low,
  input  logic [11:0] range_high,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [43:0] range_total,
  input  logic [9:0]  new_version,
  input  logic [2:0]  status,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAVES = 4096;
  localparam int NODES = 65536;
  localparam int VERSIONS = 1024;

  logic [43:0] node_sum [NODES];
  int          lch [NODES];
  int          rch [NODES];
  int          root_of [VERSIONS];
  int          ver_cnt;
  int          free_node;
  logic [12:0] span_reg;
  result_t     expected_q[$];

  assign pending = expected_q.size();

  function automatic int span_len();
    if (span_reg == 0) return 1;
    if (span_reg > LEAVES) return LEAVES;
    return int'(span_reg);
  endfunction

  function automatic logic [43:0] span_total(int node, int lo, int hi, int a, int b);
    int mid;
    if (a > hi || b < lo) return '0;
    if (a <= lo && hi <= b) return node_sum[node];
    mid = lo + (hi - lo) / 2;
    return span_total(lch[node], lo, mid, a, b) + span_total(rch[node], mid + 1, hi, a, b);
  endfunction

  // path copy: new node at depth k gets index free_node + k, as allocated root first
  function automatic status_e write_elem(int ver, int pos, logic [31:0] val);
    int path_old [16];
    int path_mid [16];
    int lo, hi, node, depth, n, child;
    lo = 0;
    hi = span_len() - 1;
    node = root_of[ver];
    depth = 0;
    while (lo < hi) begin
      path_old[depth] = node;
      path_mid[depth] = lo + (hi - lo) / 2;
      if (pos <= path_mid[depth]) begin
        node = lch[node];
        hi = path_mid[depth];
      end else begin
        node = rch[node];
        lo = path_mid[depth] + 1;
      end
      depth++;
    end
    if (free_node + depth + 1 > NODES) return ST_POOL_FULL;
    n = free_node + depth;
    node_sum[n] = {12'd0, val};
    lch[n] = 0;
    rch[n] = 0;
    for (int k = depth - 1; k >= 0; k--) begin
      n = free_node + k;
      child = n + 1;
      if (pos <= path_mid[k]) begin
        lch[n] = child;
        rch[n] = rch[path_old[k]];
      end else begin
        lch[n] = lch[path_old[k]];
        rch[n] = child;
      end
      node_sum[n] = node_sum[lch[n]] + node_sum[rch[n]];
    end
    root_of[ver] = free_node;
    free_node += depth + 1;
    return ST_OK;
  endfunction

  function automatic result_t apply_op(opcode_e op, int ver, int pos, logic [31:0] val,
                                      int a, int b);
    result_t r;
    int len;
    r = '{total: '0, new_version: '0, status: ST_OK};
    len = span_len();
    if (op == OP_NONE) return r;
    if (ver >= ver_cnt) begin
      r.status = ST_BAD_VER;
    end else if (op == OP_SET) begin
      if (pos >= len) r.status = ST_BAD_IDX;
      else r.status = write_elem(ver, pos, val);
    end else if (op == OP_SUM) begin
      if (a >= len || b >= len) r.status = ST_BAD_IDX;
      else if (a <= b) r.total = span_total(root_of[ver], 0, len - 1, a, b);
    end else begin
      if (ver_cnt >= VERSIONS) begin
        r.status = ST_VER_FULL;
      end else begin
        root_of[ver_cnt] = root_of[ver];
        r.new_version = 10'(ver_cnt);
        ver_cnt++;
      end
    end
    return r;
  endfunction

  function automatic void add_expected(result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      expected_q.delete();
      node_sum[0] = '0;
      lch[0] = 0;
      rch[0] = 0;
      root_of[0] = 0;
      ver_cnt = 1;
      free_node = 1;
      span_reg = LENGTH_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result transaction, total", range_total, 0);
        end else begin
          want = expected_q.pop_front();
          if (range_total !== want.total) report("range_total", range_total, want.total);
          if (new_version !== want.new_version)
            report("new_version", new_version, want.new_version);
          if (status !== want.status) report("status", status, want.status);
        end
      end
      if (in_valid && in_ready)
        add_expected(apply_op(opcode_e'(opcode), int'(version_sel), int'(position), value,
                              int'(range_low), int'(range_high)));
      if (cfg_valid && cfg_ready) span_reg = active_length;
    end
  end
endmodule

/* verif/tb_persistent_range_sum_tree.sv */
module tb_persistent_range_sum_tree import prst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] active_length;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [9:0]  version_sel;
  logic [11:0] position;
  logic [31:0] value;
  logic [11:0] range_low;
  logic [11:0] range_high;
  logic        out_valid;
  logic        out_ready;
  logic [43:0] range_total;
  logic [9:0]  new_version;
  logic [2:0]  status;
  int          pending;
  int          errors;
  int          cycles = 0;
  int          idle_pct;
  int          stall_pct;
  int          versions_made;
  int          cur_len;

  persistent_range_sum_tree uut (.*);

  persistent_range_sum_tree_chk chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send(opcode_e op, int ver, int pos, logic [31:0] val, int a, int b);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 0;
      while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
      @(negedge clk);
    end
    opcode = op;
    version_sel = 10'(ver);
    position = 12'(pos);
    value = val;
    range_low = 12'(a);
    range_high = 12'(b);
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op == OP_COPY && ver < versions_made && versions_made < 1024) versions_made++;
  endtask

  task automatic drain();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_len(int v);
    drain();
    active_length = 13'(v);
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
    cur_len = (v == 0) ? 1 : (v > 4096 ? 4096 : v);
  endtask

  function automatic int pick_idx();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
    return $urandom_range(0, cur_len - 1);
  endfunction

  task automatic random_item();
    int r, ver, a, b;
    r = $urandom_range(0, 99);
    ver = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                       : $urandom_range(0, versions_made - 1);
    a = pick_idx();
    b = ($urandom_range(0, 3) == 0) ? pick_idx() : $urandom_range(a, cur_len - 1);
    if (b >= 4096) b = 4095;
    if (r < 42) send(OP_SET, ver, pick_idx(), $urandom(), a, b);
    else if (r < 84) send(OP_SUM, ver, $urandom_range(0, 4095), $urandom(), a, b);
    else if (r < 96) send(OP_COPY, ver, $urandom_range(0, 4095), $urandom(), a, b);
    else send(OP_NONE, ver, $urandom_range(0, 4095), $urandom(), a, b);
  endtask

  initial begin
    int lens [7] = '{4096, 1, 2, 13, 8191, 0, 300};
    rst = 1;
    cfg_valid = 0;
    active_length = '0;
    in_valid = 0;
    opcode = '0;
    version_sel = '0;
    position = '0;
    value = '0;
    range_low = '0;
    range_high = '0;
    idle_pct = 0;
    stall_pct = 0;
    versions_made = 1;
    cur_len = 4096;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, empty range, errors, every opcode
    send(OP_SUM, 0, 0, 0, 0, 4095);
    send(OP_SET, 0, 0, 32'hFFFF_FFFF, 0, 0);
    send(OP_SET, 0, 4095, 32'hFFFF_FFFF, 0, 0);
    send(OP_SET, 0, 2048, 0, 0, 0);
    send(OP_SUM, 0, 0, 0, 0, 4095);
    send(OP_SUM, 0, 0, 0, 4095, 4095);
    send(OP_SUM, 0, 0, 0, 4095, 0);
    send(OP_COPY, 0, 0, 0, 0, 0);
    send(OP_SET, 1, 1, 32'h5555_AAAA, 0, 0);
    send(OP_SUM, 1, 0, 0, 0, 4095);
    send(OP_SUM, 0, 0, 0, 0, 4095);
    send(OP_SET, 1023, 0, 1, 0, 0);
    send(OP_SUM, 2, 0, 0, 0, 1);
    send(OP_COPY, 5, 0, 0, 0, 0);
    send(OP_NONE, 0, 4095, 32'hFFFF_FFFF, 4095, 4095);
    write_len(100);
    send(OP_SET, 0, 100, 7, 0, 0);
    send(OP_SET, 0, 99, 7, 0, 0);
    send(OP_SUM, 0, 0, 0, 0, 100);
    send(OP_SUM, 0, 0, 0, 100, 0);
    send(OP_SUM, 0, 0, 0, 0, 99);

    for (int ph = 0; ph < 7; ph++) begin
      write_len(lens[ph]);
      idle_pct = (ph % 4 == 1) ? 88 : (ph % 4 == 3) ? 32 : 0;
      stall_pct = (ph % 4 == 2) ? 88 : (ph % 4 == 3) ? 32 : 0;
      for (int i = 0; i < 25; i++) begin
        random_item();
        if (ph == 2 && i == 12) drain();
      end
    end

    // fill the version table, then act on the newest versions
    idle_pct = 0;
    stall_pct = 32;
    while (versions_made < 1024)
      send(OP_COPY, $urandom_range(0, versions_made - 1), 0, 0, 0, 0);
    send(OP_COPY, 0, 0, 0, 0, 0);
    send(OP_SET, 1023, cur_len - 1, $urandom(), 0, 0);
    send(OP_SUM, 1023, 0, 0, 0, cur_len - 1);
    for (int i = 0; i < 60; i++) random_item();

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/prst_pkg.sv
sv/prst_pool.sv
sv/prst_roots.sv
sv/prst_engine.sv
sv/persistent_range_sum_tree.sv
verif/persistent_range_sum_tree_chk.sv
verif/tb_persistent_range_sum_tree.sv
